/* design/spd_pkg.sv */
// Shared types and constants for the sensor packet deframer.
// Depends on nothing; imported by every module of the block.
package spd_pkg;

    // Position within a packet while receiving
    typedef enum logic [3:0] {
        POS_HUNT     = 4'd0,
        POS_START_LO = 4'd1,
        POS_ADDR0    = 4'd2,
        POS_ADDR1    = 4'd3,
        POS_ADDR2    = 4'd4,
        POS_ADDR3    = 4'd5,
        POS_KIND     = 4'd6,
        POS_LEN_HI   = 4'd7,
        POS_LEN_LO   = 4'd8,
        POS_PAYLOAD  = 4'd9
    } pos_t;

    // Result status codes
    typedef enum logic [2:0] {
        ST_PAYLOAD   = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_BAD_START = 3'd2,
        ST_TIMEOUT   = 3'd3,
        ST_ZERO_LEN  = 3'd4
    } status_t;

    // Input command code carried in tuser
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [0:0] CFG_START_CODE = 1'b0;
    localparam logic [0:0] CFG_TIMEOUT    = 1'b1;

    // Configuration reset values
    localparam logic [15:0] START_CODE_RESET = 16'hEF01;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;

    // One result record as it travels from the parser to the output stage
    typedef struct packed {
        status_t     status;
        logic [7:0]  payload_byte;
        logic [15:0] payload_offset;
        logic        last;
        logic [7:0]  packet_kind;
        logic [15:0] packet_length;
        logic [31:0] device_address;
    } spd_result_t;

endpackage

/* design/sensor_packet_deframer_top.sv */
// Sensor packet deframer: one byte or tick accepted per cycle. The result record
// is written to the queue when the transfer is accepted and then loaded into the
// output register, from which it is offered on the master side. Sustained rate is
// one item per cycle; the slave side stalls only while the result queue is full.
// rst_n is asynchronous and clears the parser, the queue and the output stage and
// restores the start code (EF01h) and timeout (1000 ticks).
module sensor_packet_deframer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    input  logic [0:0]  s_axis_tuser,   // command[0]
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // payload_byte[7:0], payload_offset[23:8],
                                        // packet_kind[31:24], packet_length[47:32],
                                        // device_address[79:48]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    output logic        m_axis_tlast    // last
);
    import spd_pkg::*;

    spd_result_t res;
    spd_result_t q_data;
    logic        res_valid;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;

    // Parser
    spd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_command (s_axis_tuser[0]),
        .in_byte    (s_axis_tdata),
        .queue_full (q_full),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Result queue
    spd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // Output stage
    spd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast)
    );

endmodule

/* design/spd_front.sv */
// Parser front end: accepts bytes and ticks, tracks the packet fields and
// produces result records. Depends on spd_pkg.
module spd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_command,
    input  logic [7:0]          in_byte,
    input  logic                queue_full,
    output logic                res_valid,
    output spd_pkg::spd_result_t res
);
    import spd_pkg::*;

    logic [15:0] start_code_reg;
    logic [15:0] timeout_reg;
    pos_t        pos_reg, pos_next;
    logic [31:0] address_reg, address_next;
    logic [7:0]  kind_reg, kind_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] pcount_reg, pcount_next;
    logic [15:0] tick_reg, tick_next;

    logic        accept;
    logic        is_tick;
    logic [15:0] tick_inc;
    logic [15:0] pcount_inc;
    logic [15:0] length_lo;
    logic        timeout_hit;
    logic        start_bad;
    logic        len_zero;
    logic        pay_done;
    logic        emit;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign is_tick  = (in_command == CMD_TICK);

    // Condition terms shared by next-state and output logic
    assign tick_inc    = tick_reg + 16'd1;
    assign pcount_inc  = pcount_reg + 16'd1;
    assign length_lo   = {length_reg[15:8], in_byte};
    assign timeout_hit = is_tick && (tick_inc >= timeout_reg);
    assign start_bad   = (in_byte != start_code_reg[7:0]);
    assign len_zero    = (length_lo == 16'd0);
    assign pay_done    = (pcount_inc == length_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= START_CODE_RESET;
            timeout_reg    <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_CODE: start_code_reg <= cfg_data;
                CFG_TIMEOUT:    timeout_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Field position next state
    always_comb
    begin
        pos_next = pos_reg;
        if (is_tick)
        begin
            if (timeout_hit)
                pos_next = POS_HUNT;
        end
        else
        begin
            case (pos_reg)
                POS_HUNT:
                    if (in_byte == start_code_reg[15:8])
                        pos_next = POS_START_LO;
                POS_START_LO: pos_next = start_bad ? POS_HUNT : POS_ADDR0;
                POS_ADDR0:    pos_next = POS_ADDR1;
                POS_ADDR1:    pos_next = POS_ADDR2;
                POS_ADDR2:    pos_next = POS_ADDR3;
                POS_ADDR3:    pos_next = POS_KIND;
                POS_KIND:     pos_next = POS_LEN_HI;
                POS_LEN_HI:   pos_next = POS_LEN_LO;
                POS_LEN_LO:   pos_next = len_zero ? POS_HUNT : POS_PAYLOAD;
                default:      pos_next = pay_done ? POS_HUNT : pos_reg;
            endcase
        end
    end

    // Datapath updates and result record
    always_comb
    begin
        address_next = address_reg;
        kind_next    = kind_reg;
        length_next  = length_reg;
        pcount_next  = pcount_reg;
        tick_next    = tick_reg;
        emit         = 1'b0;
        res.status         = ST_PAYLOAD;
        res.payload_byte   = 8'd0;
        res.payload_offset = 16'd0;
        res.last           = 1'b0;
        if (is_tick)
        begin
            tick_next = tick_inc;
            if (timeout_hit)
            begin
                tick_next   = 16'd0;
                pcount_next = 16'd0;
                emit        = 1'b1;
                res.status  = ST_TIMEOUT;
                res.last    = 1'b1;
            end
        end
        else
        begin
            case (pos_reg)
                POS_HUNT: ;
                POS_START_LO:
                    if (start_bad)
                    begin
                        tick_next   = 16'd0;
                        pcount_next = 16'd0;
                        emit        = 1'b1;
                        res.status  = ST_BAD_START;
                        res.last    = 1'b1;
                    end
                POS_ADDR0, POS_ADDR1, POS_ADDR2, POS_ADDR3:
                    address_next = {address_reg[23:0], in_byte};
                POS_KIND:   kind_next = in_byte;
                POS_LEN_HI: length_next = {in_byte, 8'd0};
                POS_LEN_LO:
                begin
                    length_next = length_lo;
                    pcount_next = 16'd0;
                    if (len_zero)
                    begin
                        tick_next  = 16'd0;
                        emit       = 1'b1;
                        res.status = ST_ZERO_LEN;
                        res.last   = 1'b1;
                    end
                end
                default:
                begin
                    // Payload byte, checksum bytes included
                    emit               = 1'b1;
                    res.payload_byte   = in_byte;
                    res.payload_offset = pcount_reg;
                    pcount_next        = pcount_inc;
                    if (pay_done)
                    begin
                        pcount_next = 16'd0;
                        tick_next   = 16'd0;
                        res.status  = ST_COMPLETE;
                        res.last    = 1'b1;
                    end
                end
            endcase
        end
        res.packet_kind    = kind_next;
        res.packet_length  = length_next;
        res.device_address = address_next;
    end

    assign res_valid = accept && emit;

    // State registers, updated on each accepted transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_HUNT;
            address_reg <= 32'd0;
            kind_reg    <= 8'd0;
            length_reg  <= 16'd0;
            pcount_reg  <= 16'd0;
            tick_reg    <= 16'd0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            address_reg <= address_next;
            kind_reg    <= kind_next;
            length_reg  <= length_next;
            pcount_reg  <= pcount_next;
            tick_reg    <= tick_next;
        end
    end

`ifndef SYNTHESIS
    // A result that ends a reception leaves the parser hunting with counts cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.last) |=> (pos_reg == POS_HUNT && tick_reg == 16'd0
                                      && pcount_reg == 16'd0))
        else $error("parser not re-armed after end of reception");

    // Payload is only received against a non-zero length
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == POS_PAYLOAD) |-> (length_reg != 16'd0))
        else $error("payload phase with zero length");

    // The payload count stays below the captured length
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == POS_PAYLOAD) |-> (pcount_reg < length_reg))
        else $error("payload count reached length without completing");
`endif

endmodule

/* design/spd_queue.sv */
// Short result queue between parser and output stage.
// Depends on spd_pkg for the result record type.
module spd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  spd_pkg::spd_result_t push_data,
    output logic                full,
    input  logic                pop,
    output spd_pkg::spd_result_t pop_data,
    output logic                empty
);
    import spd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    spd_result_t       entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

`ifndef SYNTHESIS
    // Fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");

    // A lone push leaves something to read
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> !empty)
        else $error("queue empty after push");

    // A lone pop takes exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("queue count wrong after pop");
`endif

endmodule

/* design/spd_back.sv */
// Output stage: takes result records from the queue into an output register
// and presents them as stream transfers. Depends on spd_pkg.
module spd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  spd_pkg::spd_result_t q_data,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [79:0]         m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tlast
);
    import spd_pkg::*;

    logic        valid_reg;
    spd_result_t out_reg;

    // Load a new record whenever the register is free or being drained
    assign q_pop = !q_empty && (!valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || m_tready)
            valid_reg <= !q_empty;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_reg <= q_data;
    end

    // Pack the record onto the stream
    assign m_tvalid = valid_reg;
    assign m_tdata  = {out_reg.device_address, out_reg.packet_length,
                       out_reg.packet_kind, out_reg.payload_offset,
                       out_reg.payload_byte};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

endmodule

/* tb/spd_result_checker.sv */
// Scoreboard for the sensor packet deframer: tracks the parser state on every
// accepted slave transfer and checks each master transfer in arrival order.
// Depends on spd_pkg for the result record, the status and the position codes.
`timescale 1ns / 1ps

module spd_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic [0:0]  s_axis_tuser,   // command
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,   // payload_byte, payload_offset, packet_kind,
                                        // packet_length, device_address
    input  logic [2:0]  m_axis_tuser,   // status
    input  logic        m_axis_tlast,
    output int          mismatches,
    output int          outstanding,
    output int          results_checked,
    output int          packets_done,
    output int          receptions_aborted
);
    import spd_pkg::*;

    spd_result_t expected_q[$];

    // mirrored configuration and parser state
    logic [15:0] code_q;
    logic [15:0] timeout_q;
    pos_t        field_pos;
    logic [31:0] addr_q;
    logic [7:0]  kind_q;
    logic [15:0] length_q;
    logic [15:0] bytes_in;
    logic [15:0] ticks_seen;

    int err_count;
    int checked_count;
    int done_count;
    int abort_count;

    // back to hunting with counts cleared; header registers are kept
    task automatic restart_hunt();
        field_pos  = POS_HUNT;
        bytes_in   = 16'd0;
        ticks_seen = 16'd0;
    endtask

    task automatic queue_result(input status_t st, input logic [7:0] b,
                                input logic [15:0] offs);
        spd_result_t rec;
        rec.status         = st;
        rec.payload_byte   = b;
        rec.payload_offset = offs;
        rec.last           = (st != ST_PAYLOAD);
        rec.packet_kind    = kind_q;
        rec.packet_length  = length_q;
        rec.device_address = addr_q;
        expected_q.insert(expected_q.size(), rec);
    endtask

    // one accepted byte or tick
    task automatic predict_transfer(input logic cmd, input logic [7:0] b);
        logic [15:0] offs;
        if (cmd == CMD_TICK)
        begin
            ticks_seen = ticks_seen + 16'd1;
            if (ticks_seen >= timeout_q)
            begin
                restart_hunt();
                queue_result(ST_TIMEOUT, 8'h00, 16'h0000);
            end
        end
        else
        begin
            case (field_pos)
                POS_HUNT:
                    if (b == code_q[15:8])
                        field_pos = POS_START_LO;
                POS_START_LO:
                    if (b != code_q[7:0])
                    begin
                        restart_hunt();
                        queue_result(ST_BAD_START, 8'h00, 16'h0000);
                    end
                    else
                        field_pos = POS_ADDR0;
                POS_ADDR0, POS_ADDR1, POS_ADDR2, POS_ADDR3:
                begin
                    addr_q    = {addr_q[23:0], b};
                    field_pos = pos_t'(field_pos + 4'd1);
                end
                POS_KIND:
                begin
                    kind_q    = b;
                    field_pos = POS_LEN_HI;
                end
                POS_LEN_HI:
                begin
                    length_q  = {b, 8'h00};
                    field_pos = POS_LEN_LO;
                end
                POS_LEN_LO:
                begin
                    length_q = {length_q[15:8], b};
                    if (length_q == 16'd0)
                    begin
                        restart_hunt();
                        queue_result(ST_ZERO_LEN, 8'h00, 16'h0000);
                    end
                    else
                    begin
                        bytes_in  = 16'd0;
                        field_pos = POS_PAYLOAD;
                    end
                end
                default:
                begin
                    offs     = bytes_in;
                    bytes_in = bytes_in + 16'd1;
                    if (bytes_in == length_q)
                    begin
                        restart_hunt();
                        queue_result(ST_COMPLETE, b, offs);
                    end
                    else
                        queue_result(ST_PAYLOAD, b, offs);
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // watch both channels and the config port
    always @(posedge clk or negedge rst_n)
    begin : monitor
        spd_result_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            code_q        = START_CODE_RESET;
            timeout_q     = TIMEOUT_RESET;
            addr_q        = 32'd0;
            kind_q        = 8'd0;
            length_q      = 16'd0;
            restart_hunt();
            err_count     = 0;
            checked_count = 0;
            done_count    = 0;
            abort_count   = 0;
            mismatches         <= 0;
            outstanding        <= 0;
            results_checked    <= 0;
            packets_done       <= 0;
            receptions_aborted <= 0;
        end
        else
        begin
            // result transfer against the oldest expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t ns: result expected none, got status %0d byte 0x%0h",
                             $time, m_axis_tuser, m_axis_tdata[7:0]);
                end
                else
                begin
                    want = expected_q.pop_front();
                    checked_count++;
                    if (want.status == ST_COMPLETE)
                        done_count++;
                    else if (want.status != ST_PAYLOAD)
                        abort_count++;
                    check_field("status", 32'(want.status), 32'(m_axis_tuser));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(m_axis_tdata[7:0]));
                    check_field("payload_offset", 32'(want.payload_offset),
                                32'(m_axis_tdata[23:8]));
                    check_field("last", 32'(want.last), 32'(m_axis_tlast));
                    check_field("packet_kind", 32'(want.packet_kind),
                                32'(m_axis_tdata[31:24]));
                    check_field("packet_length", 32'(want.packet_length),
                                32'(m_axis_tdata[47:32]));
                    check_field("device_address", want.device_address,
                                m_axis_tdata[79:48]);
                end
            end

            // register writes
            if (cfg_we)
            begin
                if (cfg_index == CFG_START_CODE)
                    code_q = cfg_data;
                else if (cfg_index == CFG_TIMEOUT)
                    timeout_q = cfg_data;
            end

            // input transfer
            if (s_axis_tvalid && s_axis_tready)
                predict_transfer(s_axis_tuser[0], s_axis_tdata);

            mismatches         <= err_count;
            outstanding        <= expected_q.size();
            results_checked    <= checked_count;
            packets_done       <= done_count;
            receptions_aborted <= abort_count;
        end
    end

endmodule

/* tb/sensor_packet_deframer_top_test.sv */
// Stimulus and verdict for the sensor packet deframer: directed frames, then
// random packet traffic over several start code and timeout settings.
// Depends on spd_pkg, sensor_packet_deframer_top and spd_result_checker.
`timescale 1ns / 1ps

module sensor_packet_deframer_top_test;
    import spd_pkg::*;

    localparam int   HALF_PERIOD = 4;
    localparam logic CMD_BYTE    = 1'b0;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // rx_byte
    logic [0:0]  s_axis_tuser;     // command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;     // payload_byte, payload_offset, packet_kind,
                                   // packet_length, device_address
    logic [2:0]  m_axis_tuser;     // status
    logic        m_axis_tlast;

    int mismatches;
    int outstanding;
    int results_checked;
    int packets_done;
    int receptions_aborted;

    // stimulus controls
    bit          tx_steady;
    bit          rx_steady;
    int          hold_len;
    int          items_sent;
    logic [15:0] cur_code;
    logic [15:0] cur_timeout;

    sensor_packet_deframer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    spd_result_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_axis_tvalid      (s_axis_tvalid),
        .s_axis_tready      (s_axis_tready),
        .s_axis_tdata       (s_axis_tdata),
        .s_axis_tuser       (s_axis_tuser),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata),
        .m_axis_tuser       (m_axis_tuser),
        .m_axis_tlast       (m_axis_tlast),
        .mismatches         (mismatches),
        .outstanding        (outstanding),
        .results_checked    (results_checked),
        .packets_done       (packets_done),
        .receptions_aborted (receptions_aborted)
    );

    always #HALF_PERIOD clk = ~clk;

    // one transfer on the slave side, with an optional gap in front
    task automatic drive(input logic cmd, input logic [7:0] b);
        if (!tx_steady && $urandom_range(0, 99) < 28)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        drive(CMD_BYTE, b);
    endtask

    // rx_byte is don't-care on a tick, so it carries noise
    task automatic send_tick();
        drive(CMD_TICK, 8'($urandom));
    endtask

    task automatic send_byte_mix(input logic [7:0] b, input int tick_pct);
        if ($urandom_range(0, 99) < tick_pct)
            send_tick();
        send_byte(b);
    endtask

    task automatic send_header(input logic [31:0] addr, input logic [7:0] kind,
                               input logic [15:0] len, input int tick_pct);
        send_byte(cur_code[15:8]);
        send_byte_mix(cur_code[7:0], tick_pct);
        for (int i = 3; i >= 0; i--)
            send_byte_mix(addr[8*i +: 8], tick_pct);
        send_byte_mix(kind, tick_pct);
        send_byte_mix(len[15:8], tick_pct);
        send_byte_mix(len[7:0], tick_pct);
    endtask

    task automatic send_packet(input logic [15:0] decl_len, input int nbytes,
                               input int tick_pct);
        send_header($urandom, 8'($urandom), decl_len, tick_pct);
        repeat (nbytes) send_byte_mix(8'($urandom), tick_pct);
    endtask

    // pause the sender until every result is in, plus pipeline latency
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] code, input logic [15:0] tmo);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_CODE;
        cfg_data  <= code;
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_code    = code;
        cur_timeout = tmo;
    endtask

    // mostly well-formed frames, with zero-length frames, bad starts and line
    // noise; with a short timeout also truncated frames, recovered by ticks
    task automatic random_sequence();
        int          pick;
        bit          short_tmo;
        logic [15:0] len;
        logic [7:0]  b;
        short_tmo = (cur_timeout <= 16'd64);
        pick      = $urandom_range(0, 99);
        if (pick < 60 || (pick >= 78 && pick < 88 && !short_tmo))
        begin
            if ($urandom_range(0, 9) == 0)
                len = 16'($urandom_range(9, 40));
            else
                len = 16'($urandom_range(1, 8));
            send_packet(len, int'(len), short_tmo ? 8 : 1);
        end
        else if (pick < 70)
            send_packet(16'd0, 0, short_tmo ? 8 : 1);
        else if (pick < 78)
        begin
            // bad start: low byte forced to differ
            send_byte(cur_code[15:8]);
            b = 8'($urandom);
            if (b == cur_code[7:0])
                b = ~b;
            send_byte(b);
        end
        else if (pick < 88)
        begin
            // truncated frame with any declared length, ended by timeout
            send_packet(16'($urandom), $urandom_range(0, 4), 8);
            repeat (int'(cur_timeout)) send_tick();
        end
        else
        begin
            repeat ($urandom_range(1, 3))
            begin
                b = 8'($urandom);
                if (!short_tmo && b == cur_code[15:8])
                    b = ~b;
                if (short_tmo && $urandom_range(0, 1) == 0)
                    send_tick();
                else
                    send_byte(b);
            end
        end
    endtask

    // receiver: random back-pressure, steady stretches and one long hold
    initial
    begin : receiver
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_len != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            m_axis_tready <= rx_steady || ($urandom_range(0, 99) >= 28);
        end
    end

    // main stimulus and verdict
    initial
    begin : stimulus
        int phase_end;
        int waited;
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_START_CODE;
        cfg_data      = 16'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = CMD_BYTE;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        hold_len      = 0;
        items_sent    = 0;
        cur_code      = START_CODE_RESET;
        cur_timeout   = TIMEOUT_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: hunt drops, full frame, bad start, zero length
        send_byte(8'h00);
        send_byte(8'hFF);
        send_header(32'hFF00_A55A, 8'hFF, 16'd2, 0);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(cur_code[15:8]);
        send_byte(~cur_code[7:0]);
        send_header(32'h0000_0000, 8'h00, 16'd0, 0);
        send_tick();

        // shortest timeout: idle tick, then a timeout inside the header
        drain();
        set_config(START_CODE_RESET, 16'd1);
        send_tick();
        send_byte(cur_code[15:8]);
        send_byte(cur_code[7:0]);
        send_byte(8'h12);
        send_byte(8'h34);
        send_tick();

        // random traffic, one setting per phase
        for (int p = 0; p < 5; p++)
        begin
            drain();
            case (p)
                0: set_config(START_CODE_RESET, TIMEOUT_RESET);
                1: set_config(16'h0000, 16'd1);
                2: set_config(16'hFFFF, 16'hFFFF);
                3: set_config(16'($urandom), 16'($urandom_range(5, 40)));
                default: set_config(16'($urandom), 16'($urandom_range(2, 64)));
            endcase
            if (p == 0)
            begin
                // receiver holds off while a long frame fills the queue
                hold_len  = 80;
                tx_steady = 1'b1;
                send_packet(16'd40, 40, 0);
                tx_steady = 1'b0;
                drain();
            end
            if (p == 3)
            begin
                tx_steady = 1'b1;
                rx_steady = 1'b1;
            end
            phase_end = items_sent + 110;
            while (items_sent < phase_end)
            begin
                random_sequence();
                if (items_sent > phase_end - 70)
                begin
                    tx_steady = 1'b0;
                    rx_steady = 1'b0;
                end
            end
        end

        // wind down
        s_axis_tvalid <= 1'b0;
        waited = 0;
        repeat (2) @(posedge clk);
        while (outstanding != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        $display("Sent %0d byte/tick transfers under six start code and timeout settings;",
                 items_sent);
        $display("%0d results checked: %0d frames complete, %0d receptions aborted.",
                 results_checked, packets_done, receptions_aborted);
        if (mismatches == 0 && outstanding == 0)
            $display("sensor_packet_deframer_top_test: clean");
        else
        begin
            if (outstanding != 0)
                $display("%0d expected results never arrived", outstanding);
            $display("sensor_packet_deframer_top_test: errors");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("run did not finish in the time allowed");
        $display("sensor_packet_deframer_top_test: errors");
        $finish;
    end

endmodule

/* filelist.f */
design/spd_pkg.sv
design/spd_front.sv
design/spd_queue.sv
design/spd_back.sv
design/sensor_packet_deframer_top.sv
tb/spd_result_checker.sv
tb/sensor_packet_deframer_top_test.sv
